/* rtl/bcsa_pkg.sv */
// shared types and constants for the block cache slot allocator
`default_nettype none

package bcsa_pkg;

  // field widths of the request and result items
  localparam int unsigned AddrW    = 32;
  localparam int unsigned StampW   = 32;
  localparam int unsigned SlotIdxW = 3;

  // result outcome codes
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FREE  = 2'd1,
    OUT_CLEAN = 2'd2,
    OUT_DIRTY = 2'd3
  } outcome_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  // request item
  typedef struct packed {
    logic [AddrW-1:0]  blk_addr;
    logic [StampW-1:0] access_time;
    logic              is_write;
  } req_t;

  // result item
  typedef struct packed {
    outcome_e              outcome;
    logic [SlotIdxW-1:0]   slot_index;
    logic [AddrW-1:0]      writeback_addr;
  } rsp_t;

  // one slot entry as held in the slot memory
  typedef struct packed {
    logic [AddrW-1:0]  tag;
    logic [StampW-1:0] stamp;
    logic              dirty;
  } slot_t;

endpackage

`default_nettype wire

/* rtl/block_cache_slot_allocator.sv */
// fully associative slot allocator with lru victim choice and dirty write-back
//
//  channel   signals                     direction  handshake
//  request   start, busy, req_i          in         taken when start high, busy low
//  result    done_o, rsp_o               out        one-cycle strobe, no stall
//
// from acceptance to its result strobe an item passes through the slot
// memory reads, one per slot, the drain of the read pipe, the exit from the
// scan, the read-modify-write of the chosen slot and the output register.
// the next item may be accepted in the cycle its predecessor's result shows.
// reset clears the valid bits and the control; the slot memory needs no clear.
`default_nettype none

module block_cache_slot_allocator
  import bcsa_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire req_t req_i,
  output logic      busy,
  output logic      done_o,
  output rsp_t      rsp_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  state_e state_q, state_d;

  req_t            req_q;
  logic [CW-1:0]   issue_q, issue_d;
  logic            rvld_q, rvld_d;
  logic [IW-1:0]   ridx_q, ridx_d;
  logic [SLOTS-1:0] valid_q, valid_d;

  logic            hit_q, hit_d;
  logic [IW-1:0]   hit_idx_q, hit_idx_d;
  logic            hit_dirty_q, hit_dirty_d;
  logic            free_q, free_d;
  logic [IW-1:0]   free_idx_q, free_idx_d;
  logic [IW-1:0]   old_idx_q, old_idx_d;
  logic [StampW-1:0] old_stamp_q, old_stamp_d;
  logic [AddrW-1:0]  old_tag_q, old_tag_d;
  logic            old_dirty_q, old_dirty_d;

  logic            done_q, done_d;
  rsp_t            rsp_q, rsp_d;

  logic            ram_re, ram_we;
  logic [IW-1:0]   ram_waddr;
  slot_t           ram_wdata, ram_rdata;
  logic            accept;
  logic            rslot_valid;
  logic [IW-1:0]   chosen;
  logic [IW+SlotIdxW-1:0] chosen_ext;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // slot memory holding tag, time stamp and dirty bit
  bcsa_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (issue_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // state, scan bookkeeping, valid bits and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rvld_q  <= 1'b0;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= rvld_d;
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  // payload, scan bookkeeping, scan results and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    issue_q     <= issue_d;
    ridx_q      <= ridx_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    hit_dirty_q <= hit_dirty_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    old_idx_q   <= old_idx_d;
    old_stamp_q <= old_stamp_d;
    old_tag_q   <= old_tag_d;
    old_dirty_q <= old_dirty_d;
    rsp_q       <= rsp_d;
  end

  assign rslot_valid = valid_q[ridx_q];

  // winner of the scan: hit, else lowest free slot, else oldest slot
  always_comb begin
    if (hit_q) begin
      chosen = hit_idx_q;
    end else if (free_q) begin
      chosen = free_idx_q;
    end else begin
      chosen = old_idx_q;
    end
  end
  assign chosen_ext = (IW + SlotIdxW)'(chosen);

  // next state, scan compare and slot update
  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    rvld_d      = 1'b0;
    ridx_d      = issue_q[IW-1:0];
    valid_d     = valid_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_dirty_d = hit_dirty_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    old_idx_d   = old_idx_q;
    old_stamp_d = old_stamp_q;
    old_tag_d   = old_tag_q;
    old_dirty_d = old_dirty_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = chosen;
    ram_wdata.tag   = req_q.blk_addr;
    ram_wdata.stamp = req_q.access_time;
    ram_wdata.dirty = hit_q ? (hit_dirty_q || req_q.is_write) : req_q.is_write;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          issue_d = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      ST_SCAN: begin
        // issue one slot read per cycle
        if (issue_q < CW'(SLOTS)) begin
          ram_re  = 1'b1;
          rvld_d  = 1'b1;
          issue_d = issue_q + CW'(1);
        end else if (!rvld_q) begin
          state_d = ST_WRITE;
        end
        // look at the slot read last cycle
        if (rvld_q) begin
          if (rslot_valid) begin
            if (!hit_q && (ram_rdata.tag == req_q.blk_addr)) begin
              hit_d       = 1'b1;
              hit_idx_d   = ridx_q;
              hit_dirty_d = ram_rdata.dirty;
            end
            if ((ridx_q == '0) || (ram_rdata.stamp < old_stamp_q)) begin
              old_idx_d   = ridx_q;
              old_stamp_d = ram_rdata.stamp;
              old_tag_d   = ram_rdata.tag;
              old_dirty_d = ram_rdata.dirty;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = ridx_q;
          end
        end
      end
      ST_WRITE: begin
        // write back the chosen slot and form the result
        ram_we          = 1'b1;
        valid_d[chosen] = 1'b1;
        done_d          = 1'b1;
        state_d         = ST_IDLE;
        rsp_d.slot_index     = chosen_ext[SlotIdxW-1:0];
        rsp_d.writeback_addr = '0;
        if (hit_q) begin
          rsp_d.outcome = OUT_HIT;
        end else if (free_q) begin
          rsp_d.outcome = OUT_FREE;
        end else if (old_dirty_q) begin
          rsp_d.outcome        = OUT_DIRTY;
          rsp_d.writeback_addr = old_tag_q;
        end else begin
          rsp_d.outcome = OUT_CLEAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a result strobe follows exactly the slot update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_WRITE))
    else $error("result strobe without slot update");

  // an accepted item keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // only a dirty victim reports a write-back address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.outcome != OUT_DIRTY)) |-> (rsp_o.writeback_addr == '0))
    else $error("write-back address without dirty victim");

  // the slot memory is never read and written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("slot memory read during write");
`endif

endmodule

`default_nettype wire

/* rtl/bcsa_ram.sv */
// generic single write port ram with one registered read port
`default_nettype none

module bcsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* verif/block_cache_slot_allocator_test.sv */
// self-checking testbench for the block cache slot allocator
`timescale 1ns / 100ps

module block_cache_slot_allocator_test
  import bcsa_pkg::*;
();

  localparam int unsigned SlotCount  = 8;
  localparam int unsigned RandItems  = 450;
  localparam int unsigned PoolSize   = 12;
  localparam int unsigned DrainLimit = 400;
  localparam int unsigned SettleCyc  = 20;

  // tracks the slot store and holds the results it predicts, oldest first
  class slot_alloc_scoreboard;
    bit [SlotCount-1:0] valid_bits;
    bit [SlotCount-1:0] dirty_bits;
    bit [AddrW-1:0]     tag_mem[SlotCount];
    bit [StampW-1:0]    stamp_mem[SlotCount];
    rsp_t               expected_q[$];
    int unsigned        fail_count;

    function new();
      valid_bits = '0;
      dirty_bits = '0;
      fail_count = 0;
      for (int i = 0; i < SlotCount; i++) begin
        tag_mem[i]   = '1;
        stamp_mem[i] = '0;
      end
    endfunction

    // predict the allocation for one accepted item and update the slot store
    function void note_request(req_t r);
      int   idx;
      int   oldest;
      int   chosen;
      int   free_idx;
      bit   hit;
      bit   have_free;
      rsp_t res;
      oldest    = 0;
      chosen    = 0;
      free_idx  = 0;
      hit       = 1'b0;
      have_free = 1'b0;
      // scan: stop on a hit, remember first free and strictly oldest slot
      for (idx = 0; idx < SlotCount && !hit; idx++) begin
        if (valid_bits[idx]) begin
          if (tag_mem[idx] == r.blk_addr) begin
            hit    = 1'b1;
            chosen = idx;
          end else if (stamp_mem[idx] < stamp_mem[oldest]) begin
            oldest = idx;
          end
        end else if (!have_free) begin
          have_free = 1'b1;
          free_idx  = idx;
        end
      end
      res.writeback_addr = '0;
      if (hit) begin
        res.outcome        = OUT_HIT;
        dirty_bits[chosen] = dirty_bits[chosen] | r.is_write;
      end else begin
        if (have_free) begin
          chosen      = free_idx;
          res.outcome = OUT_FREE;
        end else begin
          chosen = oldest;
          if (dirty_bits[chosen]) begin
            res.outcome        = OUT_DIRTY;
            res.writeback_addr = tag_mem[chosen];
          end else begin
            res.outcome = OUT_CLEAN;
          end
        end
        valid_bits[chosen] = 1'b1;
        tag_mem[chosen]    = r.blk_addr;
        dirty_bits[chosen] = r.is_write;
      end
      stamp_mem[chosen] = r.access_time;
      res.slot_index    = SlotIdxW'(chosen);
      expected_q.push_back(res);
    endfunction

    // compare one result against the oldest prediction
    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      if (got.outcome !== want.outcome) begin
        $display("%0t: outcome mismatch, expected %s, actual %h", $time,
                 want.outcome.name(), got.outcome);
        fail_count++;
      end
      if (got.slot_index !== want.slot_index) begin
        $display("%0t: slot_index mismatch, expected %0d, actual %0d", $time,
                 want.slot_index, got.slot_index);
        fail_count++;
      end
      if (got.writeback_addr !== want.writeback_addr) begin
        $display("%0t: writeback_addr mismatch, expected %h, actual %h", $time,
                 want.writeback_addr, got.writeback_addr);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  slot_alloc_scoreboard sb = new();

  block_cache_slot_allocator #(.SLOTS(SlotCount)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // result monitor, the receiver never stalls
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(rsp_o);
    end
  end

  // hard stop for a hung block
  initial begin
    #5_000_000;
    $display("[block_cache_slot_allocator] ERROR");
    $finish;
  end

  function automatic req_t make_req(logic [AddrW-1:0] addr, logic [StampW-1:0] stamp,
                                    logic wr);
    req_t r;
    r.blk_addr    = addr;
    r.access_time = stamp;
    r.is_write    = wr;
    return r;
  endfunction

  // offer one item after an optional idle gap and hold it until accepted
  task automatic send_request(input req_t r, input int unsigned gap);
    bit taken;
    taken = 1'b0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy) begin
        taken = 1'b1;
        sb.note_request(r);
      end
    end
    @(negedge clk_i);
  endtask

  // hold off until every predicted result has shown up
  task automatic wait_for_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    req_t               directed_q[$];
    logic [AddrW-1:0]   addr_pool[PoolSize];
    logic [StampW-1:0]  stamp_now;
    logic [AddrW-1:0]   addr;
    logic [StampW-1:0]  stamp;
    int unsigned        roll;
    int unsigned        wait_cyc;
    bit                 quiet;

    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: all-ones address must miss into a free slot, not hit the empty tag
    directed_q.push_back(make_req('1, 32'd5, 1'b0));
    directed_q.push_back(make_req(32'h0000_0000, 32'd0, 1'b1));
    directed_q.push_back(make_req('1, 32'd5, 1'b1));
    // fill the rest with extreme and tied stamps
    directed_q.push_back(make_req(32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
    directed_q.push_back(make_req(32'h0000_0001, 32'd0, 1'b0));
    directed_q.push_back(make_req(32'h7FFF_FFFF, 32'd7, 1'b1));
    directed_q.push_back(make_req(32'hFFFF_FFFE, 32'd0, 1'b1));
    directed_q.push_back(make_req(32'h1234_5678, 32'h8000_0000, 1'b0));
    directed_q.push_back(make_req(32'h5555_5555, 32'd3, 1'b0));
    // full: victims by smallest stamp, lowest index on ties, clean and dirty
    directed_q.push_back(make_req(32'hA5A5_A5A5, 32'd10, 1'b0));
    directed_q.push_back(make_req(32'h5A5A_5A5A, 32'd11, 1'b1));
    directed_q.push_back(make_req(32'hAAAA_AAAA, 32'd12, 1'b0));
    directed_q.push_back(make_req(32'h8000_0000, 32'd13, 1'b1));
    directed_q.push_back(make_req(32'h1234_5678, 32'd14, 1'b0));
    directed_q.push_back(make_req(32'hDEAD_BEEF, 32'd15, 1'b0));
    directed_q.push_back(make_req(32'hCAFE_F00D, 32'd16, 1'b1));
    directed_q.push_back(make_req('1, 32'hFFFF_FFFF, 1'b0));
    directed_q.push_back(make_req(32'h0F0F_0F0F, 32'd17, 1'b0));
    directed_q.push_back(make_req(32'hF0F0_F0F0, 32'd18, 1'b1));
    directed_q.push_back(make_req(32'h0000_0000, 32'd19, 1'b0));
    foreach (directed_q[i]) begin
      send_request(directed_q[i], pick_gap(1'b0));
    end
    wait_for_idle();

    // random: a small address pool keeps hits and evictions frequent
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
    stamp_now = $urandom_range(0, 1000);
    quiet     = 1'b0;
    for (int n = 0; n < RandItems; n++) begin
      if (n % 50 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (n % 120 == 119) begin
        wait_for_idle();
        foreach (addr_pool[i]) addr_pool[i] = $urandom();
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) addr = addr_pool[$urandom_range(0, PoolSize - 1)];
      else if (roll < 97) addr = $urandom();
      else addr = '1;
      stamp_now = stamp_now + $urandom_range(0, 3);
      stamp     = ($urandom_range(0, 9) == 0) ? $urandom() : stamp_now;
      send_request(make_req(addr, stamp, 1'($urandom_range(0, 1))), pick_gap(quiet));
    end
    start <= 1'b0;

    // drain, then let the pipe settle
    wait_cyc = 0;
    while (sb.pending() != 0 && wait_cyc < DrainLimit) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (SettleCyc) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time, sb.pending());
    end

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("[block_cache_slot_allocator] OK");
    end else begin
      $display("[block_cache_slot_allocator] ERROR");
    end
    $finish;
  end

endmodule
